/* rtl/sem_pkg.sv */
package sem_pkg;
	localparam int DefMaxWidth = 1024;
	localparam int CfgW = 16;
	localparam logic [0:0] CfgWidth = 1'b0;
	localparam logic [0:0] CfgHeight = 1'b1;
	localparam logic [16:0] SatLimit = 17'd64771;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} pix_t;

	// one result job: three columns (left, mid, right), each top/mid/bottom
	typedef struct packed {
		pix_t [2:0] lc;
		pix_t [2:0] mc;
		pix_t [2:0] rc;
		logic last;
	} job_t;
endpackage

/* rtl/sem_front.sv */
module sem_front import sem_pkg::*; #(
	parameter int MAX_WIDTH = DefMaxWidth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_idx,
	input  logic [CfgW-1:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	output logic        q_push,
	output job_t        q_job,
	input  logic        q_full
);
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);

	typedef enum logic [2:0] {
		ST_RD  = 3'b001,
		ST_EM1 = 3'b010,
		ST_EM2 = 3'b100
	} st_t;

	st_t st_q;
	logic [10:0] width_q;
	logic [15:0] height_q;
	logic [CW-1:0] col_q;
	logic [15:0] row_q;
	pix_t mem_a [MAX_WIDTH];
	pix_t mem_b [MAX_WIDTH];
	pix_t rd_a_q, rd_b_q, cur_q;
	pix_t [8:0] win_q;
	logic [CW-1:0] c_q;
	logic [15:0] r_q;
	logic last_q;
	logic [AW-1:0] idx_q;

	logic [CW-1:0] w_eff;
	logic [15:0] h_eff;
	logic [AW-1:0] idx;
	logic last_item;
	pix_t cur;
	pix_t up1, up2;
	logic take;

	always_comb begin
		if (width_q == 11'd0) w_eff = CW'(1);
		else if ({21'd0, width_q} > 32'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
		else w_eff = CW'(width_q);
		h_eff = (height_q == 16'd0) ? 16'd1 : height_q;
		idx = (32'(col_q) < 32'(MAX_WIDTH)) ? col_q[AW-1:0] : AW'(MAX_WIDTH - 1);
		last_item = (32'(col_q) + 32'd1) >= 32'(w_eff);
		cur = (!func && row_q < h_eff) ? pix_t'({red_in, green_in, blue_in}) : '0;
		up1 = (r_q >= 16'd1) ? rd_a_q : '0;
		up2 = (r_q >= 16'd2) ? rd_b_q : '0;
	end

	assign in_stall = (st_q != ST_RD);
	assign take = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (take) begin
			rd_a_q <= mem_a[idx];
			rd_b_q <= mem_b[idx];
			cur_q <= cur;
		end
		if (st_q == ST_EM1) begin
			mem_a[idx_q] <= cur_q;
			mem_b[idx_q] <= up1;
		end
	end

	always_ff @(posedge clk) if (take) idx_q <= idx;

	// the window shift happens once the line store read is back
	pix_t [8:0] win_n;
	always_comb begin
		win_n = {cur_q, up1, up2, win_q[8:3]};
	end

	logic emit_a, emit_b;
	assign emit_a = (r_q >= 16'd1) && (c_q >= CW'(1));
	assign emit_b = (r_q >= 16'd1) && last_q;

	always_comb begin
		q_push = 1'b0;
		q_job = '0;
		if (st_q == ST_EM1 && emit_a && !q_full) begin
			q_push = 1'b1;
			q_job.lc = (c_q >= CW'(2)) ? win_n[2:0] : '0;
			q_job.mc = win_n[5:3];
			q_job.rc = win_n[8:6];
			q_job.last = !emit_b;
		end else if ((st_q == ST_EM1 && !emit_a && emit_b) || st_q == ST_EM2) begin
			q_push = !q_full;
			q_job.lc = (c_q >= CW'(1)) ? win_q[5:3] : '0;
			q_job.mc = win_q[8:6];
			q_job.rc = '0;
			q_job.last = 1'b1;
			if (st_q == ST_EM1) begin
				q_job.lc = (c_q >= CW'(1)) ? win_n[5:3] : '0;
				q_job.mc = win_n[8:6];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RD;
			width_q <= 11'd640;
			height_q <= 16'd480;
			col_q <= '0;
			row_q <= '0;
			win_q <= '0;
			c_q <= '0;
			r_q <= '0;
			last_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CfgWidth:  width_q <= cfg_data[10:0];
					CfgHeight: height_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (st_q)
				ST_RD: begin
					if (take) begin
						c_q <= col_q;
						r_q <= row_q;
						last_q <= last_item;
						if (last_item) begin
							col_q <= '0;
							row_q <= (row_q >= h_eff) ? 16'd0 : row_q + 16'd1;
						end else begin
							col_q <= col_q + CW'(1);
						end
						st_q <= ST_EM1;
					end
				end
				ST_EM1: begin
					if (!q_full) begin
						win_q <= win_n;
						st_q <= (emit_a && emit_b) ? ST_EM2 : ST_RD;
					end
				end
				ST_EM2: begin
					if (!q_full) st_q <= ST_RD;
				end
				default: st_q <= ST_RD;
			endcase
		end
	end
endmodule

/* rtl/sem_fifo.sv */
module sem_fifo import sem_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t din,
	output logic full,
	output logic pop_valid,
	input  logic pop,
	output job_t dout
);
	job_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign full = (cnt_q == 3'd4);
	assign pop_valid = (cnt_q != 3'd0);
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk) if (push && !full) mem_q[wp_q] <= din;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wp_q <= wp_q + 2'd1;
			if (pop && pop_valid) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(push && !full) - 3'(pop && pop_valid);
		end
	end
endmodule

/* rtl/sem_back.sv */
module sem_back import sem_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	input  job_t job,
	output logic job_pop,
	output logic out_valid,
	input  logic out_stall,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out,
	output logic last_of_run
);
	// load sums squared gradients, then 8-step root search (one bit a cycle)
	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_ROOT = 3'b010,
		B_OUT  = 3'b100
	} bst_t;

	bst_t st_q;
	logic [2:0][16:0] s_q;
	logic [2:0][7:0] n_q;
	logic [2:0] bit_q;
	logic last_q;

	function automatic logic [10:0] gabs(input logic signed [11:0] v);
		return (v < 0) ? 11'(-v) : 11'(v);
	endfunction

	logic [2:0][16:0] s_n;
	always_comb begin
		logic [7:0] tl, ml, bl, tm, bm, tr, mr, br;
		logic signed [11:0] gx, gy;
		logic [10:0] ax, ay;
		logic [21:0] sq;
		for (int k = 0; k < 3; k++) begin
			tl = job.lc[0][8*(2-k) +: 8]; ml = job.lc[1][8*(2-k) +: 8];
			bl = job.lc[2][8*(2-k) +: 8];
			tm = job.mc[0][8*(2-k) +: 8]; bm = job.mc[2][8*(2-k) +: 8];
			tr = job.rc[0][8*(2-k) +: 8]; mr = job.rc[1][8*(2-k) +: 8];
			br = job.rc[2][8*(2-k) +: 8];
			gx = 12'(tr) + 12'(br) + 12'({mr, 1'b0}) - 12'(tl) - 12'(bl) - 12'({ml, 1'b0});
			gy = 12'(bl) + 12'(br) + 12'({bm, 1'b0}) - 12'(tl) - 12'(tr) - 12'({tm, 1'b0});
			ax = gabs(gx);
			ay = gabs(gy);
			sq = 22'(ax * ax) + 22'(ay * ay);
			s_n[k] = (sq >= 22'(SatLimit)) ? SatLimit : sq[16:0];
		end
	end

	// largest n with n*(n-1) < s; saturated sum gives 255
	logic [2:0][7:0] try_n;
	logic [2:0] ok;
	always_comb begin
		logic [16:0] p;
		for (int k = 0; k < 3; k++) begin
			try_n[k] = n_q[k] | (8'd1 << bit_q);
			p = 17'(try_n[k]) * 17'(try_n[k] - 8'd1);
			ok[k] = (p < s_q[k]);
		end
	end

	assign job_pop = (st_q == B_IDLE) && job_valid;
	assign out_valid = (st_q == B_OUT);
	assign red_out = n_q[0];
	assign green_out = n_q[1];
	assign blue_out = n_q[2];
	assign last_of_run = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			s_q <= '0;
			n_q <= '0;
			bit_q <= '0;
			last_q <= 1'b0;
		end else begin
			unique case (st_q)
				B_IDLE: if (job_valid) begin
					s_q <= s_n;
					n_q <= '0;
					bit_q <= 3'd7;
					last_q <= job.last;
					st_q <= B_ROOT;
				end
				B_ROOT: begin
					for (int k = 0; k < 3; k++)
						if (ok[k]) n_q[k] <= try_n[k];
					if (bit_q == 3'd0) st_q <= B_OUT;
					else bit_q <= bit_q - 3'd1;
				end
				B_OUT: if (!out_stall) st_q <= B_IDLE;
				default: st_q <= B_IDLE;
			endcase
		end
	end
endmodule

/* rtl/sobel_edge_magnitude_rgb.sv */
// Sobel edge magnitude on RGB video, 3x3 window, zero outside the image.
// Input channel: in_valid/in_stall with func, red_in, green_in, blue_in
// in raster order. func=1 is a flush item; send image_width of them after
// each frame to close the bottom row.
// Output channel: out_valid/out_stall with red_out, green_out, blue_out
// and last_of_run, set on the final result caused by one input item.
// Pixel (r,c) is answered when the item at (r+1,c+1) arrives; the last
// column also answers at the row end. The first row gives no results.
// The front reads the line stores as it takes an item, then updates the
// window and queues a result (a second one at a row end), with in_stall
// high meanwhile. The back loads a job, runs an eight-step root search
// and outputs it (plus any output stall), so it sets sustained throughput.
// A 4-entry queue sits between. Reset clears counters, window and control;
// line stores need no clearing. Width/height reset to 640/480, written by
// cfg_we/cfg_idx/cfg_data; the user must write them only while idle (the
// block won't enforce it). A stalled output fills the queue, stalling input.
module sobel_edge_magnitude_rgb import sem_pkg::*; #(
	parameter int MAX_WIDTH = DefMaxWidth
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [0:0] cfg_idx,
	input  logic [CfgW-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic func,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	output logic out_valid,
	input  logic out_stall,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out,
	output logic last_of_run
);
	logic q_push, q_full, q_valid, q_pop;
	job_t q_in, q_out;

	sem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data, .in_valid, .in_stall,
		.func, .red_in, .green_in, .blue_in,
		.q_push, .q_job(q_in), .q_full
	);

	sem_fifo u_fifo (
		.clk, .arst_n, .push(q_push), .din(q_in), .full(q_full),
		.pop_valid(q_valid), .pop(q_pop), .dout(q_out)
	);

	sem_back u_back (
		.clk, .arst_n, .job_valid(q_valid), .job(q_out), .job_pop(q_pop),
		.out_valid, .out_stall, .red_out, .green_out, .blue_out, .last_of_run
	);
endmodule
